>>> hdl/qpmc_pkg.sv
`timescale 1ns / 1ps

package qpmc_pkg;

   localparam int SCALE_SHIFT = 7;
   localparam int SIG_MAX     = 32640;
   localparam int PERIOD_MAX  = 127;
   localparam int TOTAL_MAX   = 32767;
   localparam int DRIVE_MAX   = 255;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [1:0] {
      KIND_ENCODER    = 2'd0,
      KIND_PERIOD     = 2'd1,
      KIND_CONTROL    = 2'd2,
      KIND_READ_CLEAR = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_INTEGRAL_LIMIT = 3'd2,
      CSR_TARGET_SPEED   = 3'd3,
      CSR_DRIVE_ENABLED  = 3'd4
   } csr_index_type;

   typedef struct packed {
      kind_type kind;
      logic     pin_a;
      logic     pin_b;
   } req_type;

   typedef struct packed {
      logic signed [8:0]  control_signal;
      logic signed [15:0] proportional_term;
      logic signed [15:0] integral_term;
      logic signed [7:0]  period_ticks;
      logic signed [15:0] total_ticks;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] kp_gain;
      logic signed [15:0] ki_gain;
      logic [14:0]        integral_limit;
      logic signed [15:0] target_speed;
      logic               drive_enabled;
   } cfg_type;

endpackage

>>> hdl/quadrature_pi_motor_controller_core.sv
`timescale 1ns / 1ps
// A transaction is accepted into the input register; its result is computed from there,
// registered in the output register, and presented from it until taken at a rising edge.
// Throughput: one transaction per cycle unless rsp_stall holds a result back.
// Reset is synchronous and clears the control registers, the accumulators, the tick
// counters and the last drive value to zero.

module quadrature_pi_motor_controller_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qpmc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qpmc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qpmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qpmc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import qpmc_pkg::*;

   cfg_type cfg;
   req_type req_data_ff;
   rsp_type rsp_data_ff;
   rsp_type result;
   logic    req_valid_ff;
   logic    rsp_valid_ff;
   logic    advance;
   logic    update;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign update    = advance && req_valid_ff;
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   qpmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   qpmc_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .update (update),
      .req    (req_data_ff),
      .cfg    (cfg),
      .rsp    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
         end
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_data_ff <= req_data;
      end
      if (update) begin
         rsp_data_ff <= result;
      end
   end

endmodule

>>> hdl/qpmc_csr.sv
`timescale 1ns / 1ps

module qpmc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [qpmc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [qpmc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output qpmc_pkg::cfg_type                    cfg
);
   import qpmc_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_KP_GAIN:        cfg_ff.kp_gain        <= csr_wdata;
            CSR_KI_GAIN:        cfg_ff.ki_gain        <= csr_wdata;
            CSR_INTEGRAL_LIMIT: cfg_ff.integral_limit <= csr_wdata[14:0];
            CSR_TARGET_SPEED:   cfg_ff.target_speed   <= csr_wdata;
            CSR_DRIVE_ENABLED:  cfg_ff.drive_enabled  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

endmodule

>>> hdl/qpmc_datapath.sv
`timescale 1ns / 1ps

module qpmc_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              update,
   input  qpmc_pkg::req_type req,
   input  qpmc_pkg::cfg_type cfg,
   output qpmc_pkg::rsp_type rsp
);
   import qpmc_pkg::*;

   localparam logic signed [17:0] SIG_HI    = 18'(SIG_MAX);
   localparam logic signed [17:0] SIG_LO    = -18'(SIG_MAX);
   localparam logic signed [17:0] PER_HI    = 18'(PERIOD_MAX);
   localparam logic signed [17:0] PER_LO    = -18'(PERIOD_MAX);
   localparam logic signed [17:0] TOT_HI    = 18'(TOTAL_MAX);
   localparam logic signed [17:0] TOT_LO    = -18'(TOTAL_MAX);
   localparam logic signed [17:0] DRV_HI    = 18'(DRIVE_MAX);
   localparam logic signed [17:0] DRV_LO    = -18'(DRIVE_MAX);
   localparam logic signed [17:0] ROUND_ADJ = 18'((1 << SCALE_SHIFT) - 1);

   // Adds b to a; a positive step saturates at the upper bound only, any
   // other step at the lower bound only.
   function automatic logic signed [17:0] sat_add(input logic signed [17:0] a,
                                                  input logic signed [17:0] b,
                                                  input logic signed [17:0] lo,
                                                  input logic signed [17:0] hi);
      logic signed [17:0] s;
      s = a + b;
      if (b > 18'sd0) begin
         return (s < hi) ? s : hi;
      end
      return (s > lo) ? s : lo;
   endfunction

   function automatic logic signed [17:0] clamp_sig(input logic signed [31:0] v);
      if (v > 32'(SIG_MAX)) begin
         return SIG_HI;
      end
      if (v < -32'(SIG_MAX)) begin
         return SIG_LO;
      end
      return v[17:0];
   endfunction

   logic               prev_a_ff, prev_a_in;
   logic               prev_b_ff, prev_b_in;
   logic signed [15:0] prop_ff, prop_in;
   logic signed [15:0] integ_ff, integ_in;
   logic signed [7:0]  period_ff, period_in;
   logic signed [15:0] total_ff, total_in;
   logic signed [8:0]  drive_ff, drive_in;

   logic               dir;
   logic signed [17:0] prop_x, integ_x, kp_x, ki_x, lim_x, pu, iu, tu;
   logic signed [17:0] sum, sum_adj, quot, drive_x, total_step;
   logic signed [31:0] prod_p, prod_i;

   always_comb begin
      prop_x  = 18'(prop_ff);
      integ_x = 18'(integ_ff);
      kp_x    = 18'(cfg.kp_gain);
      ki_x    = 18'(cfg.ki_gain);
      lim_x   = {3'b000, cfg.integral_limit};
      dir     = prev_b_ff ^ req.pin_a;
      pu      = dir ? -kp_x : kp_x;
      iu      = dir ? -ki_x : ki_x;
      tu      = dir ? 18'sd1 : -18'sd1;
      prod_p  = 32'(cfg.target_speed) * 32'(cfg.kp_gain);
      prod_i  = 32'(cfg.target_speed) * 32'(cfg.ki_gain);
      sum     = sat_add(prop_x, integ_x, SIG_LO, SIG_HI);
      sum_adj = sum + ((sum < 18'sd0) ? ROUND_ADJ : 18'sd0);
      quot    = sum_adj >>> SCALE_SHIFT;
      drive_x = (quot > DRV_HI) ? DRV_HI : ((quot < DRV_LO) ? DRV_LO : quot);

      prev_a_in  = prev_a_ff;
      prev_b_in  = prev_b_ff;
      prop_in    = prop_ff;
      integ_in   = integ_ff;
      period_in  = period_ff;
      total_step = 18'(total_ff);
      drive_in   = drive_ff;

      case (req.kind)
         KIND_ENCODER: begin
            if (req.pin_a != prev_a_ff || req.pin_b != prev_b_ff) begin
               prop_in    = 16'(sat_add(prop_x, pu, SIG_LO, SIG_HI));
               integ_in   = 16'(sat_add(integ_x, iu, -lim_x, lim_x));
               period_in  = 8'(sat_add(18'(period_ff), tu, PER_LO, PER_HI));
               total_step = sat_add(18'(total_ff), tu, TOT_LO, TOT_HI);
               prev_a_in  = req.pin_a;
               prev_b_in  = req.pin_b;
            end
         end
         KIND_PERIOD: begin
            prop_in   = 16'(clamp_sig(prod_p));
            integ_in  = 16'(sat_add(integ_x, clamp_sig(prod_i), -lim_x, lim_x));
            period_in = '0;
         end
         KIND_CONTROL: begin
            drive_in = cfg.drive_enabled ? drive_x[8:0] : 9'sd0;
         end
         default: begin
         end
      endcase

      total_in = (req.kind == KIND_READ_CLEAR) ? 16'sd0 : total_step[15:0];

      rsp.control_signal    = drive_in;
      rsp.proportional_term = prop_in;
      rsp.integral_term     = integ_in;
      rsp.period_ticks      = period_in;
      rsp.total_ticks       = total_step[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_a_ff <= 1'b0;
         prev_b_ff <= 1'b0;
         prop_ff   <= '0;
         integ_ff  <= '0;
         period_ff <= '0;
         total_ff  <= '0;
         drive_ff  <= '0;
      end else if (update) begin
         prev_a_ff <= prev_a_in;
         prev_b_ff <= prev_b_in;
         prop_ff   <= prop_in;
         integ_ff  <= integ_in;
         period_ff <= period_in;
         total_ff  <= total_in;
         drive_ff  <= drive_in;
      end
   end

endmodule
